// ===== hdl/iem_pkg.sv =====
// shared types and constants for the ipv4 ecn marker
package iem_pkg;

  localparam int unsigned HDR_BYTES = 34;
  localparam int unsigned IDX_W     = $clog2(HDR_BYTES);

  localparam logic [31:0] SRC_RESET = 32'h9DF0_D123;
  localparam logic [7:0]  ECN_MASK  = 8'h03;
  localparam logic [7:0]  ECN_MARK  = 8'h02;
  localparam logic [15:0] WORD_MASK = 16'hFFFF;

  // ethertype for ipv4
  localparam logic [7:0] ETYPE_HI = 8'h08;
  localparam logic [7:0] ETYPE_LO = 8'h00;

  // byte positions inside the held header
  localparam logic [IDX_W-1:0] POS_ETYPE_HI = IDX_W'(12);
  localparam logic [IDX_W-1:0] POS_ETYPE_LO = IDX_W'(13);
  localparam logic [IDX_W-1:0] POS_IP_FIRST = IDX_W'(14);
  localparam logic [IDX_W-1:0] POS_TOS      = IDX_W'(15);
  localparam logic [IDX_W-1:0] POS_CSUM_HI  = IDX_W'(24);
  localparam logic [IDX_W-1:0] POS_CSUM_LO  = IDX_W'(25);
  localparam logic [IDX_W-1:0] POS_SRC_0    = IDX_W'(26);
  localparam logic [IDX_W-1:0] POS_SRC_3    = IDX_W'(29);
  localparam logic [IDX_W-1:0] POS_LAST     = IDX_W'(HDR_BYTES - 1);

  // sum of up to ten 16-bit words
  localparam int unsigned SUM_W = 20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       marked;
  } out_item_t;

  // per-byte events into the header checker
  typedef struct packed {
    logic             take;
    logic             calc;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } hdr_ev_t;

  // verdict and new checksum for the held header
  typedef struct packed {
    logic        mark;
    logic [15:0] csum;
  } hdr_res_t;

  typedef enum logic [3:0] {
    ST_BUF   = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PASS  = 4'b1000
  } state_t;

endpackage

// ===== hdl/ipv4_ecn_marker_core.sv =====
// top level of the ipv4 ecn marker: header buffer, drain pipeline and pass-through
//
// usage:
//   in_*  : one frame byte per request, in_last on the final byte of a frame
//   out_* : one frame byte per request, with marked set on rewritten frames
//   cfg_* : writes the ipv4 source address to match, taken whenever presented
//           (cfg_ready is always high); write it only while no frame is open
// the first 34 bytes of a frame go into a 34-entry header ram, one per cycle,
// and produce no output. on the 34th byte the block decides in its calc state
// whether to mark and forms the new checksum, then reads the ram back out,
// one byte per cycle while out_stall is low, rewriting tos and checksum on the
// fly for a marked frame. a frame that ends before 34 bytes is read back
// unchanged right after its last byte. input is stalled during the decision
// and the read-back; after that bytes go straight through the output register
// at one per cycle while out_stall is low. the first header byte passes the
// calc state, the ram read register and the output register after the 34th
// byte is accepted. out_stall freezes the ram read register and the output
// register; nothing is dropped. synchronous reset clears control state and
// restores the default source address; ram contents are not cleared.
module ipv4_ecn_marker_core
  import iem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // control registers
  state_t           st_r, st_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;       // bytes held so far
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt; // next ram entry to read
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic             fin_last_r, fin_last_nxt;
  logic             full_r, full_nxt;     // header reached 34 bytes
  logic [31:0]      src_r, src_nxt;

  // read stage: ram data plus what travels with it
  logic             rd_v_r, rd_v_nxt;
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] rd_pos_r;
  logic             rd_last_r;
  logic             rd_mk_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  // header ram
  logic [7:0]       hdr_mem [HDR_BYTES];

  logic             out_free;
  logic             s1_adv;
  logic             buf_take;
  logic             pass_take;
  logic             issue;
  logic             issue_end;
  logic [7:0]       sub_byte;
  hdr_ev_t          ev;
  hdr_res_t         res;

  // the source address register takes every write
  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = rd_v_r && out_free;
  assign buf_take  = (st_r == ST_BUF) && in_valid;
  // pass bytes wait until the last header byte has left the read stage
  assign pass_take = (st_r == ST_PASS) && in_valid && !rd_v_r && out_free;
  assign issue     = (st_r == ST_DRAIN) && (!rd_v_r || s1_adv);
  assign issue_end = issue && (rd_idx_r == last_idx_r);

  assign in_stall  = !((st_r == ST_BUF) || ((st_r == ST_PASS) && !rd_v_r && out_free));

  always_comb begin
    ev.take = buf_take;
    ev.calc = (st_r == ST_CALC);
    ev.idx  = cnt_r;
    ev.data = in_data.in_byte;
  end

  iem_hdr_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev       (ev),
    .src_addr (src_r),
    .res      (res)
  );

  // control path
  always_comb begin
    st_nxt       = st_r;
    cnt_nxt      = cnt_r;
    rd_idx_nxt   = rd_idx_r;
    last_idx_nxt = last_idx_r;
    fin_last_nxt = fin_last_r;
    full_nxt     = full_r;
    src_nxt      = src_r;

    if (cfg_valid) begin
      src_nxt = cfg_data;
    end

    unique case (st_r)
      ST_BUF: begin
        if (buf_take) begin
          if (cnt_r == POS_LAST) begin
            // full header held: decide and recompute checksum
            last_idx_nxt = POS_LAST;
            fin_last_nxt = in_data.in_last;
            full_nxt     = 1'b1;
            cnt_nxt      = '0;
            st_nxt       = ST_CALC;
          end else if (in_data.in_last) begin
            // short frame: flush what is held, unchanged
            last_idx_nxt = cnt_r;
            fin_last_nxt = 1'b1;
            full_nxt     = 1'b0;
            cnt_nxt      = '0;
            st_nxt       = ST_DRAIN;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end
      end
      ST_CALC: begin
        st_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (issue) begin
          if (issue_end) begin
            rd_idx_nxt = '0;
            st_nxt     = (full_r && !fin_last_r) ? ST_PASS : ST_BUF;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
      end
      ST_PASS: begin
        if (pass_take && in_data.in_last) begin
          st_nxt = ST_BUF;
        end
      end
      default: begin
        st_nxt = ST_BUF;
      end
    endcase
  end

  // tos and checksum substitution for marked frames
  always_comb begin
    sub_byte = rd_data_r;
    if (rd_mk_r) begin
      if (rd_pos_r == POS_TOS) begin
        sub_byte = (rd_data_r & ~ECN_MASK) | ECN_MARK;
      end else if (rd_pos_r == POS_CSUM_HI) begin
        sub_byte = res.csum[15:8];
      end else if (rd_pos_r == POS_CSUM_LO) begin
        sub_byte = res.csum[7:0];
      end
    end
  end

  // read stage and output register
  always_comb begin
    rd_v_nxt = rd_v_r;
    if (issue) begin
      rd_v_nxt = 1'b1;
    end else if (s1_adv) begin
      rd_v_nxt = 1'b0;
    end

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv) begin
      out_nxt.out_byte = sub_byte;
      out_nxt.out_last = rd_last_r;
      out_nxt.marked   = rd_mk_r;
      out_valid_nxt    = 1'b1;
    end else if (pass_take) begin
      out_nxt.out_byte = in_data.in_byte;
      out_nxt.out_last = in_data.in_last;
      out_nxt.marked   = res.mark;
      out_valid_nxt    = 1'b1;
    end
  end

  // header ram: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (buf_take) begin
      hdr_mem[cnt_r] <= in_data.in_byte;
    end
    if (issue) begin
      rd_data_r <= hdr_mem[rd_idx_r];
      rd_pos_r  <= rd_idx_r;
      rd_last_r <= issue_end && fin_last_r;
      rd_mk_r   <= full_r && res.mark;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      st_r        <= ST_BUF;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      last_idx_r  <= '0;
      fin_last_r  <= 1'b0;
      full_r      <= 1'b0;
      src_r       <= SRC_RESET;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      last_idx_r  <= last_idx_nxt;
      fin_last_r  <= fin_last_nxt;
      full_r      <= full_nxt;
      src_r       <= src_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/iem_hdr_check.sv =====
// header qualification and ipv4 checksum accumulation as bytes stream in
module iem_hdr_check
  import iem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  hdr_ev_t     ev,
  input  logic [31:0] src_addr,
  output hdr_res_t    res
);

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             type_ok_r, type_ok_nxt;
  logic             ecn_ok_r, ecn_ok_nxt;
  logic [31:0]      src_cap_r, src_cap_nxt;
  hdr_res_t         res_r, res_nxt;

  logic [7:0]       data_mod;
  logic [SUM_W-1:0] word;
  logic             in_sum;
  logic [16:0]      fold1;
  logic [15:0]      fold2;

  always_comb begin
    data_mod = ev.data;
    if (ev.idx == POS_TOS) begin
      data_mod = (ev.data & ~ECN_MASK) | ECN_MARK;
    end
    // checksum field itself counts as zero
    in_sum = (ev.idx >= POS_IP_FIRST) && (ev.idx <= POS_LAST) &&
             (ev.idx != POS_CSUM_HI) && (ev.idx != POS_CSUM_LO);
    if (ev.idx[0]) begin
      word = SUM_W'(data_mod);
    end else begin
      word = SUM_W'({data_mod, 8'h00});
    end
  end

  always_comb begin
    sum_nxt     = sum_r;
    type_ok_nxt = type_ok_r;
    ecn_ok_nxt  = ecn_ok_r;
    src_cap_nxt = src_cap_r;
    if (ev.take) begin
      if (ev.idx == '0) begin
        sum_nxt = '0;
      end else if (in_sum) begin
        sum_nxt = sum_r + word;
      end
      if (ev.idx == POS_ETYPE_HI) begin
        type_ok_nxt = (ev.data == ETYPE_HI);
      end
      if (ev.idx == POS_ETYPE_LO) begin
        type_ok_nxt = type_ok_r && (ev.data == ETYPE_LO);
      end
      if (ev.idx == POS_TOS) begin
        ecn_ok_nxt = ((ev.data & ECN_MASK) != ECN_MASK);
      end
      if ((ev.idx >= POS_SRC_0) && (ev.idx <= POS_SRC_3)) begin
        src_cap_nxt = {src_cap_r[23:0], ev.data};
      end
    end
  end

  // end-around carry folded twice, then inverted
  always_comb begin
    fold1 = 17'(sum_r[15:0]) + 17'(sum_r[SUM_W-1:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    res_nxt = res_r;
    if (ev.calc) begin
      res_nxt.mark = type_ok_r && ecn_ok_r && (src_cap_r == src_addr);
      res_nxt.csum = ~fold2 & WORD_MASK;
    end
  end

  always_ff @(posedge clk) begin
    sum_r     <= sum_nxt;
    type_ok_r <= type_ok_nxt;
    ecn_ok_r  <= ecn_ok_nxt;
    src_cap_r <= src_cap_nxt;
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
